// ----- sv/rhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// rhsv_pkg
// Shared types and constants for the RGB to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package rhsv_pkg;

	localparam int CH_W  = 8;   // one color channel
	localparam int HUE_W = 15;  // hue, 1/64 degree
	localparam int PCT_W = 13;  // percent, 1/64
	localparam int NUM_W = 21;  // dividend width, holds 6400 * 255
	localparam int Q_W   = 13;  // quotient bits, covers 6400

	localparam logic [HUE_W-1:0] HUE_GREEN_BASE = 15'd7680;   // 120 deg
	localparam logic [HUE_W-1:0] HUE_BLUE_BASE  = 15'd15360;  // 240 deg
	localparam logic [HUE_W-1:0] HUE_FULL       = 15'd23040;  // 360 deg

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// per-pixel data that rides alongside the dividers
	typedef struct packed {
		sector_t           sector;
		logic              neg;    // hue offset below the sector base
		logic              gray;   // max == min
		logic              black;  // max == 0
		logic [PCT_W-1:0]  val;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] hue_num;
		logic [CH_W-1:0]  hue_den;
		logic [NUM_W-1:0] sat_num;
		logic [CH_W-1:0]  sat_den;
	} div_in_t;

	typedef struct packed {
		logic [Q_W-1:0] hue_q;
		logic           hue_rnz;  // hue remainder nonzero
		logic [Q_W-1:0] sat_q;
	} div_out_t;

endpackage

// ----- sv/rhsv_front.sv -----
// ----------------------------------------------------------------------------
// rhsv_front
// Input register, max/min and sector pick, dividends and value scaling.
// ----------------------------------------------------------------------------
module rhsv_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [rhsv_pkg::CH_W-1:0] red,
	input  logic [rhsv_pkg::CH_W-1:0] green,
	input  logic [rhsv_pkg::CH_W-1:0] blue,
	output logic                      out_valid,
	output rhsv_pkg::div_in_t         div_in,
	output rhsv_pkg::side_t           side
);
	import rhsv_pkg::*;

	// stage 1: input capture
	logic            valid_s1;
	logic [CH_W-1:0] r_s1, g_s1, b_s1;

	// stage 2: max/min, sector
	logic            valid_s2;
	logic [CH_W-1:0] mx_s2, delta_s2, absd_s2;
	sector_t         sector_s2;
	logic            neg_s2;

	// stage 3: dividends and value
	logic            valid_s3;
	div_in_t         div_s3;
	side_t           side_s3;

	logic [CH_W-1:0] mx_c, mn_c;
	sector_t         sector_c;
	logic [CH_W:0]   diff_c;
	logic [CH_W-1:0] absd_c;

	logic [PCT_W-1:0] t_c;
	logic [4:0]       k0_c;
	logic [CH_W:0]    r0_c;
	logic [PCT_W-1:0] val_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= red;
			g_s1 <= green;
			b_s1 <= blue;
		end
	end

	always_comb begin
		mx_c = r_s1;
		if (g_s1 > mx_c) mx_c = g_s1;
		if (b_s1 > mx_c) mx_c = b_s1;
		mn_c = r_s1;
		if (g_s1 < mn_c) mn_c = g_s1;
		if (b_s1 < mn_c) mn_c = b_s1;

		// ties go red, then green
		if (r_s1 == mx_c) begin
			sector_c = SEC_RED;
			diff_c   = {1'b0, g_s1} - {1'b0, b_s1};
		end else if (g_s1 == mx_c) begin
			sector_c = SEC_GREEN;
			diff_c   = {1'b0, b_s1} - {1'b0, r_s1};
		end else begin
			sector_c = SEC_BLUE;
			diff_c   = {1'b0, r_s1} - {1'b0, g_s1};
		end
		absd_c = diff_c[CH_W] ? diff_c[CH_W-1:0] ^ {CH_W{1'b1}} : diff_c[CH_W-1:0];
		if (diff_c[CH_W]) absd_c = absd_c + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2     <= mx_c;
			delta_s2  <= mx_c - mn_c;
			absd_s2   <= absd_c;
			sector_s2 <= sector_c;
			neg_s2    <= diff_c[CH_W];
		end
	end

	// value = 6400*mx/255 = 25*mx + floor(25*mx/255)
	always_comb begin
		t_c   = ({5'd0, mx_s2} << 4) + ({5'd0, mx_s2} << 3) + {5'd0, mx_s2};
		k0_c  = t_c[PCT_W-1:8];
		r0_c  = {1'b0, t_c[7:0]} + {4'd0, k0_c};
		val_c = t_c + {8'd0, k0_c} + {{(PCT_W-1){1'b0}}, (r0_c >= 9'd255)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// 3840 = 4096 - 256, 6400 = 4096 + 2048 + 256
			div_s3.hue_num <= ({13'd0, absd_s2} << 12) - ({13'd0, absd_s2} << 8);
			div_s3.hue_den <= delta_s2;
			div_s3.sat_num <= ({13'd0, delta_s2} << 12) + ({13'd0, delta_s2} << 11)
			                + ({13'd0, delta_s2} << 8);
			div_s3.sat_den <= mx_s2;
			side_s3.sector <= sector_s2;
			side_s3.neg    <= neg_s2;
			side_s3.gray   <= (delta_s2 == '0);
			side_s3.black  <= (mx_s2 == '0);
			side_s3.val    <= val_c;
		end
	end

	assign out_valid = valid_s3;
	assign div_in    = div_s3;
	assign side      = side_s3;

endmodule

// ----- sv/rhsv_div.sv -----
// ----------------------------------------------------------------------------
// rhsv_div
// Two-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rhsv_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  rhsv_pkg::div_in_t   div_in,
	input  rhsv_pkg::side_t     side_in,
	output logic                out_valid,
	output rhsv_pkg::div_out_t  div_out,
	output rhsv_pkg::side_t     side_out
);
	import rhsv_pkg::*;

	// stage registers
	logic              valid_s [Q_W];
	logic [NUM_W-1:0]  hrem_s  [Q_W];
	logic [NUM_W-1:0]  srem_s  [Q_W];
	logic [CH_W-1:0]   hden_s  [Q_W];
	logic [CH_W-1:0]   sden_s  [Q_W];
	logic [Q_W-1:0]    hq_s    [Q_W];
	logic [Q_W-1:0]    sq_s    [Q_W];
	side_t             side_s  [Q_W];

	// stage inputs
	logic              valid_i [Q_W];
	logic [NUM_W-1:0]  hrem_i  [Q_W];
	logic [NUM_W-1:0]  srem_i  [Q_W];
	logic [CH_W-1:0]   hden_i  [Q_W];
	logic [CH_W-1:0]   sden_i  [Q_W];
	logic [Q_W-1:0]    hq_i    [Q_W];
	logic [Q_W-1:0]    sq_i    [Q_W];
	side_t             side_i  [Q_W];

	always_comb begin
		for (int k = 0; k < Q_W; k++) begin
			if (k == 0) begin
				valid_i[k] = in_valid;
				hrem_i[k]  = div_in.hue_num;
				srem_i[k]  = div_in.sat_num;
				hden_i[k]  = div_in.hue_den;
				sden_i[k]  = div_in.sat_den;
				hq_i[k]    = '0;
				sq_i[k]    = '0;
				side_i[k]  = side_in;
			end else begin
				valid_i[k] = valid_s[k-1];
				hrem_i[k]  = hrem_s[k-1];
				srem_i[k]  = srem_s[k-1];
				hden_i[k]  = hden_s[k-1];
				sden_i[k]  = sden_s[k-1];
				hq_i[k]    = hq_s[k-1];
				sq_i[k]    = sq_s[k-1];
				side_i[k]  = side_s[k-1];
			end
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		localparam int BIT = Q_W - 1 - k;

		logic [NUM_W:0] htrial, strial;

		// quotient < 2^Q_W, so the shifted divisor never overflows NUM_W
		assign htrial = {1'b0, hrem_i[k]}
		              - ({{(NUM_W-CH_W+1){1'b0}}, hden_i[k]} << BIT);
		assign strial = {1'b0, srem_i[k]}
		              - ({{(NUM_W-CH_W+1){1'b0}}, sden_i[k]} << BIT);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_i[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				hrem_s[k] <= htrial[NUM_W] ? hrem_i[k] : htrial[NUM_W-1:0];
				srem_s[k] <= strial[NUM_W] ? srem_i[k] : strial[NUM_W-1:0];
				hq_s[k]   <= {hq_i[k][Q_W-2:0], ~htrial[NUM_W]};
				sq_s[k]   <= {sq_i[k][Q_W-2:0], ~strial[NUM_W]};
				hden_s[k] <= hden_i[k];
				sden_s[k] <= sden_i[k];
				side_s[k] <= side_i[k];
			end
		end
	end

	assign out_valid       = valid_s[Q_W-1];
	assign div_out.hue_q   = hq_s[Q_W-1];
	assign div_out.hue_rnz = (hrem_s[Q_W-1] != '0);
	assign div_out.sat_q   = sq_s[Q_W-1];
	assign side_out        = side_s[Q_W-1];

endmodule

// ----- sv/rhsv_back.sv -----
// ----------------------------------------------------------------------------
// rhsv_back
// Hue assembly from sector and quotient, special cases, output register.
// ----------------------------------------------------------------------------
module rhsv_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  rhsv_pkg::div_out_t         div_out,
	input  rhsv_pkg::side_t            side,
	output logic                       out_valid,
	output logic [rhsv_pkg::HUE_W-1:0] hue,
	output logic [rhsv_pkg::PCT_W-1:0] saturation,
	output logic [rhsv_pkg::PCT_W-1:0] brightness
);
	import rhsv_pkg::*;

	logic             valid_q;
	logic [HUE_W-1:0] hue_q;
	logic [PCT_W-1:0] sat_q, val_q;

	logic [HUE_W-1:0] base_c, q_c, hue_c;

	always_comb begin
		q_c = {{(HUE_W-Q_W){1'b0}}, div_out.hue_q};
		case (side.sector)
			SEC_RED:   base_c = side.neg ? HUE_FULL : '0;
			SEC_GREEN: base_c = HUE_GREEN_BASE;
			SEC_BLUE:  base_c = HUE_BLUE_BASE;
			default:   base_c = '0;
		endcase
		// below the base: subtract the ceiling of the offset
		if (side.gray)
			hue_c = '0;
		else if (side.neg)
			hue_c = base_c - q_c - {{(HUE_W-1){1'b0}}, div_out.hue_rnz};
		else
			hue_c = base_c + q_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= hue_c;
			sat_q <= side.black ? '0 : div_out.sat_q;
			val_q <= side.val;
		end
	end

	assign out_valid  = valid_q;
	assign hue        = hue_q;
	assign saturation = sat_q;
	assign brightness = val_q;

endmodule

// ----- sv/rgb_to_hsv_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV pixel converter, one pixel per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Takes one 8-bit RGB pixel per beat and returns hue in 1/64 degree
// (0..23039) and saturation and value in 1/64 percent (0..6400), each
// truncated toward zero. Ties for the max channel pick the sector in the
// order red, green, blue; gray pixels give hue 0, black gives saturation 0.
// A new pixel is taken every clock unless the output beat is stalled. From
// an accepted input beat to a valid output beat the pixel passes three front
// stages (capture, max/min, dividends), 13 divider stages (one quotient bit
// each, hue and saturation divided side by side) and the output register.
// The whole pipeline holds while the output beat is stalled and advances as
// soon as it is taken or the output is empty, so no beat is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // hue[14:0], saturation[27:15],
	                               // brightness[40:28], zero[47:41]
);
	import rhsv_pkg::*;

	logic en;

	logic     front_valid;
	div_in_t  front_div;
	side_t    front_side;

	logic     div_valid;
	div_out_t div_res;
	side_t    div_side;

	logic [HUE_W-1:0] hue;
	logic [PCT_W-1:0] saturation, brightness;

	// global advance: move when the output slot is free or being drained
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.out_valid (front_valid),
		.div_in    (front_div),
		.side      (front_side)
	);

	rhsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (front_valid),
		.div_in    (front_div),
		.side_in   (front_side),
		.out_valid (div_valid),
		.div_out   (div_res),
		.side_out  (div_side)
	);

	rhsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (div_valid),
		.div_out    (div_res),
		.side       (div_side),
		.out_valid  (m_tvalid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

	assign m_tdata = {7'd0, brightness, saturation, hue};

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming RGB to HSV pixel converter.
// ----------------------------------------------------------------------------
// Pixels go in on the slave stream and HSV beats are checked on the master
// stream. Each accepted pixel is run through a bit-exact predictor and the
// result is queued. Each output beat is compared field by field with the
// oldest queued result. Both sides idle at random between beats, with some
// stretches running back to back.
// ----------------------------------------------------------------------------
module tb_top;

	import rhsv_pkg::*;

	localparam int unsigned DEG60  = 3840;   // 60 degrees in 1/64 units
	localparam int unsigned DEG360 = 23040;  // full turn in 1/64 units
	localparam int unsigned PCT100 = 6400;   // 100 percent in 1/64 units
	localparam int          DRAIN_CYCLES = 40;  // well past the pipeline latency

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] bright;
	} hsv_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // red[7:0], green[15:8], blue[23:16]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // hue[14:0], saturation[27:15], brightness[40:28]

	hsv_t hsv_expected[$];
	int   n_errors  = 0;
	int   n_pixels  = 0;
	int   n_results = 0;
	bit   send_idle = 1'b1;
	bit   recv_idle = 1'b1;
	int   stall_left = 0;

	rgb_to_hsv_converter i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Exact HSV of one pixel, every field floored.
	function automatic hsv_t hsv_of_pixel(input logic [7:0] r, g, b);
		int unsigned mx, mn, delta, num, hue;
		hsv_t px;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		if (delta == 0) begin
			hue = 0;
		end else if (r == mx) begin
			if (g >= b) begin
				hue = (DEG60 * (g - b)) / delta;
			end else begin
				// below zero: wrap by a full turn, floor of 360 - x is 360 - ceil(x)
				num = DEG60 * (b - g);
				hue = DEG360 - (num + delta - 1) / delta;
			end
		end else if (g == mx) begin
			hue = (DEG60 * (2 * delta + b) - DEG60 * r) / delta;
		end else begin
			hue = (DEG60 * (4 * delta + r) - DEG60 * g) / delta;
		end
		px.hue    = hue[HUE_W-1:0];
		px.sat    = (mx == 0) ? '0 : PCT_W'((PCT100 * delta) / mx);
		px.bright = PCT_W'((PCT100 * mx) / 255);
		return px;
	endfunction

	// Channel biased toward the rails now and then.
	function automatic logic [7:0] rand_channel();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// One pixel beat; waits out a random gap first if send_idle is set, then holds until taken.
	task automatic send_pixel(input logic [7:0] r, g, b);
		int unsigned gap;
		gap = send_idle ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 24'($urandom);   // junk while idle
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hsv_expected.push_back(hsv_of_pixel(r, g, b));
		n_pixels++;
	endtask

	// Output side: random stall after a beat while recv_idle is set, check on every taken beat.
	always @(posedge clk or negedge arst_n) begin
		hsv_t got, want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else if (m_tvalid && m_tready) begin
			got = {m_tdata[14:0], m_tdata[27:15], m_tdata[40:28]};
			n_results++;
			if (hsv_expected.size() == 0) begin
				$display("%t: unexpected beat, expected none, actual hue %0d sat %0d val %0d",
					$time, got.hue, got.sat, got.bright);
				n_errors++;
			end else begin
				want = hsv_expected.pop_front();
				if (got.hue !== want.hue) begin
					$display("%t: hue expected %0d, actual %0d", $time, want.hue, got.hue);
					n_errors++;
				end
				if (got.sat !== want.sat) begin
					$display("%t: saturation expected %0d, actual %0d",
						$time, want.sat, got.sat);
					n_errors++;
				end
				if (got.bright !== want.bright) begin
					$display("%t: brightness expected %0d, actual %0d",
						$time, want.bright, got.bright);
					n_errors++;
				end
			end
			if (recv_idle && $urandom_range(0, 9) != 0) begin
				m_tready   <= 1'b0;
				stall_left <= $urandom_range(0, 8);
			end else begin
				m_tready <= 1'b1;
			end
		end else if (!m_tready) begin
			if (stall_left == 0) m_tready <= 1'b1;
			else stall_left <= stall_left - 1;
		end
	end

	// Rails, primaries, secondaries, ties for max, gray, and the hue wrap.
	task automatic test_corner_pixels();
		send_pixel(8'd0,   8'd0,   8'd0);    // black
		send_pixel(8'd255, 8'd255, 8'd255);  // white
		send_pixel(8'd128, 8'd128, 8'd128);  // mid gray
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);    // red
		send_pixel(8'd0,   8'd255, 8'd0);    // green
		send_pixel(8'd0,   8'd0,   8'd255);  // blue
		send_pixel(8'd255, 8'd255, 8'd0);    // red and green tie
		send_pixel(8'd0,   8'd255, 8'd255);  // green and blue tie
		send_pixel(8'd255, 8'd0,   8'd255);  // red and blue tie, wraps to 300
		send_pixel(8'd255, 8'd0,   8'd1);    // just under a full turn
		send_pixel(8'd255, 8'd1,   8'd0);
		send_pixel(8'd1,   8'd0,   8'd0);    // smallest nonzero max
		send_pixel(8'd0,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);  // smallest delta at full scale
		send_pixel(8'd200, 8'd100, 8'd150);  // red sector, below zero
		send_pixel(8'd30,  8'd200, 8'd90);   // green sector
		send_pixel(8'd90,  8'd30,  8'd200);  // blue sector, red above green
		send_pixel(8'd30,  8'd90,  8'd200);  // blue sector, green above red
		send_pixel(8'd120, 8'd200, 8'd20);   // green sector, red above blue
		send_pixel(8'd170, 8'd85,  8'd0);
	endtask

	// Rail-biased random pixels, idle pattern reshuffled every few dozen beats.
	task automatic test_random_pixels(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) begin
				send_idle = ($urandom_range(0, 3) != 0);
				recv_idle = ($urandom_range(0, 3) != 0);
			end
			send_pixel(rand_channel(), rand_channel(), rand_channel());
		end
	endtask

	// Ties and near-ties, where sector choice and small deltas matter.
	task automatic test_tied_channels(input int count);
		logic [7:0] base, r, g, b;
		for (int i = 0; i < count; i++) begin
			base = rand_channel();
			r = base;
			g = base;
			b = base;
			case ($urandom_range(0, 4))
				0: b = rand_channel();                         // red == green
				1: r = rand_channel();                         // green == blue
				2: g = rand_channel();                         // red == blue
				3: ;                                           // gray
				default: begin                                 // within a few counts
					r = 8'(base + $urandom_range(0, 3));
					g = 8'(base + $urandom_range(0, 3));
					b = 8'(base + $urandom_range(0, 3));
				end
			endcase
			send_pixel(r, g, b);
		end
	endtask

	// Full rate, no idling on either side.
	task automatic test_back_to_back(input int count);
		send_idle = 1'b0;
		recv_idle = 1'b0;
		for (int i = 0; i < count; i++)
			send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_corner_pixels();
		test_random_pixels(700);
		test_tied_channels(300);
		test_back_to_back(250);
		test_random_pixels(50);

		s_tvalid <= 1'b0;
		while (hsv_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d pixels sent, %0d HSV beats checked", n_pixels, n_results);
		$display("covered rails, primaries, ties for max, gray, hue wrap, full-rate runs");
		if (n_errors == 0)
			$display("rgb_to_hsv_converter: match");
		else
			$display("rgb_to_hsv_converter: mismatch");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("rgb_to_hsv_converter: mismatch");
		$finish;
	end

endmodule

// ----- rgb_to_hsv_converter.f -----
sv/rhsv_pkg.sv
sv/rhsv_front.sv
sv/rhsv_div.sv
sv/rhsv_back.sv
sv/rgb_to_hsv_converter.sv
tb/tb_top.sv
